>>> sv/rhc_pkg.sv
// Shared types, constants and the arctangent table for the RGB to HSI pipeline.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rhc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_BITS  = 16;
  localparam int NSTEP     = (FRAC_BITS > DIV_BITS) ? FRAC_BITS : DIV_BITS;
  localparam int STEP_W    = $clog2(NSTEP);
  localparam int XW        = FRAC_BITS + 12;
  localparam int REM_W     = 26;
  localparam int YPROD_W   = 41;

  localparam logic [30:0] SQRT3_Q30    = 31'd1859775393;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [17:0] THIRD_RECIP  = 18'd174763;
  localparam logic [15:0] GRAY_HUE     = 16'h4000;
  localparam logic [31:0] HUE_ROUND    = 32'h0000_8000;

  // First pipeline stage: channel statistics and raw products
  typedef struct packed {
    logic [9:0]                sum;
    logic [7:0]                mn;
    logic                      gray;
    logic                      bgt;
    logic signed [XW-1:0]      x;
    logic [YPROD_W-1:0]        yprod;
    logic [15:0]               inten;
  } prep_t;

  // State carried through the CORDIC and divider steps
  typedef struct packed {
    logic signed [XW-1:0]      x;
    logic signed [XW-1:0]      y;
    logic [31:0]               ang;
    logic [REM_W-1:0]          rem;
    logic [9:0]                den;
    logic [DIV_BITS-1:0]       q;
    logic [15:0]               inten;
    logic                      gray;
    logic                      bgt;
    logic                      zero;
  } iter_t;

  // round(atan(2^-i) / (2*pi) * 2^32)
  function automatic logic [31:0] atan_turn(input logic [4:0] s);
    logic [31:0] a;
    case (s)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> sv/rgb_to_hsi_convert.sv
// RGB to HSI converter, fully pipelined: one pixel in per cycle, one result
// out per cycle while out_stall is low. Two front stages, sixteen combined
// CORDIC/divider steps, one output stage; each step does one CORDIC angle
// rotation and one bit of the saturation division in a shared register stage.
// Stages whose valid is low fill in while the output waits, so the input
// stalls only when every stage holds an item. Hue is 65536 per turn; gray pixels
// give a quarter turn and raise achromatic. Depends on rhc_pkg and the rhc_* stages.
`default_nettype none

module rgb_to_hsi_convert (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      hue,
  output logic [15:0]      saturation,
  output logic [15:0]      intensity,
  output logic             achromatic
);

  localparam int NST = rhc_pkg::NSTEP + 3;

  logic [NST-1:0]  v;
  logic [NST-1:0]  ready;
  rhc_pkg::iter_t  pipe [rhc_pkg::NSTEP+1];

  // Stage may load when empty or when the stage after it moves on
  always_comb begin
    ready[NST-1] = !v[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      ready[i] = !v[i] || ready[i+1];
    end
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (ready[i]) begin
          v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = v[NST-1];

  rhc_prep u_prep (
    .clk    (clk),
    .load_a (ready[0]),
    .load_b (ready[1]),
    .red    (red),
    .green  (green),
    .blue   (blue),
    .dout   (pipe[0])
  );

  for (genvar k = 0; k < rhc_pkg::NSTEP; k++) begin : g_step
    rhc_iter u_iter (
      .clk  (clk),
      .load (ready[k+2]),
      .step ((rhc_pkg::STEP_W)'(k)),
      .din  (pipe[k]),
      .dout (pipe[k+1])
    );
  end

  rhc_final u_final (
    .clk        (clk),
    .load       (ready[NST-1]),
    .din        (pipe[rhc_pkg::NSTEP]),
    .hue        (hue),
    .saturation (saturation),
    .intensity  (intensity),
    .achromatic (achromatic)
  );

  // Gray pixels always report a quarter turn
  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    out_valid && achromatic |-> hue == rhc_pkg::GRAY_HUE)
    else $error("gray pixel with wrong hue");

  // Gray pixels carry no saturation
  a_gray_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && achromatic |-> saturation == 16'd0)
    else $error("gray pixel with nonzero saturation");

  // Input stalls only behind a full pipeline waiting on the output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && (&v))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> sv/rhc_prep.sv
// Two front stages: channel sums, minimum, vector products, then pre-rotation
// and divider setup. Depends on rhc_pkg.
`default_nettype none

module rhc_prep (
  input  wire logic               clk,
  input  wire logic               load_a,
  input  wire logic               load_b,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  output rhc_pkg::iter_t          dout
);

  rhc_pkg::prep_t     a_next, a;
  rhc_pkg::iter_t     b_next;
  logic signed [10:0] xd;
  logic [7:0]         dgb;
  logic [17:0]        sum257;
  logic [35:0]        iprod;
  logic [rhc_pkg::YPROD_W-1:0] yround;
  logic signed [rhc_pkg::XW-1:0] yp;
  logic [9:0]         mn3;

  // Stage A: sums, minimum, x component and the two products
  always_comb begin
    a_next.sum  = 10'(red) + 10'(green) + 10'(blue);
    a_next.mn   = (red < green) ? red : green;
    if (a_next.mn > blue) begin
      a_next.mn = blue;
    end
    a_next.gray = (red == green) && (green == blue);
    a_next.bgt  = blue > green;
    xd = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green}) - $signed({3'b000, blue});
    a_next.x = {xd[10], xd, {rhc_pkg::FRAC_BITS{1'b0}}};
    dgb = a_next.bgt ? (blue - green) : (green - blue);
    a_next.yprod = rhc_pkg::YPROD_W'(dgb) * rhc_pkg::YPROD_W'(rhc_pkg::SQRT3_Q30);
    sum257 = {a_next.sum, 8'b0} + 18'(a_next.sum);
    iprod  = 36'(sum257) * 36'(rhc_pkg::THIRD_RECIP);
    a_next.inten = iprod[34:19];
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a <= a_next;
    end
  end

  // Stage B: round y, fold the left half plane, set up the divider
  always_comb begin
    yround = a.yprod + (rhc_pkg::YPROD_W'(1) << (29 - rhc_pkg::FRAC_BITS));
    yp     = rhc_pkg::XW'(yround >> (30 - rhc_pkg::FRAC_BITS));
    if (a.x[rhc_pkg::XW-1]) begin
      b_next.x   = yp;
      b_next.y   = -a.x;
      b_next.ang = rhc_pkg::QUARTER_TURN;
    end else begin
      b_next.x   = a.x;
      b_next.y   = yp;
      b_next.ang = '0;
    end
    mn3 = 10'(a.mn) + 10'({a.mn, 1'b0});
    b_next.rem   = {mn3, 16'b0} - rhc_pkg::REM_W'(mn3);
    b_next.den   = a.sum;
    b_next.q     = '0;
    b_next.inten = a.inten;
    b_next.gray  = a.gray;
    b_next.bgt   = a.bgt;
    b_next.zero  = (a.sum == 10'd0);
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      dout <= b_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/rhc_iter.sv
// One pipeline step: a CORDIC vectoring rotation and one quotient bit of the
// saturation divider. Depends on rhc_pkg.
`default_nettype none

module rhc_iter (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [rhc_pkg::STEP_W-1:0]  step,
  input  wire rhc_pkg::iter_t              din,
  output rhc_pkg::iter_t                   dout
);

  rhc_pkg::iter_t                  nxt;
  logic signed [rhc_pkg::XW-1:0]   dx;
  logic signed [rhc_pkg::XW-1:0]   dy;
  logic [rhc_pkg::REM_W-1:0]       dsh;

  always_comb begin
    nxt = din;
    dx  = $signed(din.y) >>> step;
    dy  = $signed(din.x) >>> step;
    // Rotate toward the x axis; hold once y has reached zero
    if (32'(step) < rhc_pkg::FRAC_BITS) begin
      if (din.y[rhc_pkg::XW-1]) begin
        nxt.x   = din.x - dx;
        nxt.y   = din.y + dy;
        nxt.ang = din.ang - rhc_pkg::atan_turn(5'(step));
      end else if (din.y != '0) begin
        nxt.x   = din.x + dx;
        nxt.y   = din.y - dy;
        nxt.ang = din.ang + rhc_pkg::atan_turn(5'(step));
      end
    end
    // Restoring divide, most significant quotient bit first
    dsh = (rhc_pkg::REM_W'(din.den) << (rhc_pkg::DIV_BITS - 1)) >> step;
    if (32'(step) < rhc_pkg::DIV_BITS) begin
      if (din.rem >= dsh) begin
        nxt.rem = din.rem - dsh;
        nxt.q   = din.q | (rhc_pkg::DIV_BITS'(1) << (rhc_pkg::DIV_BITS - 1 - 32'(step)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/rhc_final.sv
// Output stage: hue folding and rounding, saturation from the quotient.
// Depends on rhc_pkg.
`default_nettype none

module rhc_final (
  input  wire logic         clk,
  input  wire logic         load,
  input  wire rhc_pkg::iter_t din,
  output logic [15:0]       hue,
  output logic [15:0]       saturation,
  output logic [15:0]       intensity,
  output logic              achromatic
);

  logic [31:0] angf;
  logic [31:0] hr;
  logic [15:0] hue_next;
  logic [15:0] sat_next;

  // Mirror the angle when blue exceeds green, then round to 16 bits
  always_comb begin
    angf     = din.bgt ? (32'd0 - din.ang) : din.ang;
    hr       = angf + rhc_pkg::HUE_ROUND;
    hue_next = din.gray ? rhc_pkg::GRAY_HUE : hr[31:16];
    sat_next = din.zero ? 16'd0 : (16'hFFFF - 16'(din.q));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hue        <= hue_next;
      saturation <= sat_next;
      intensity  <= din.inten;
      achromatic <= din.gray;
    end
  end

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for rgb_to_hsi_convert: drives random and corner RGB pixels, predicts
// hue, saturation, intensity and the gray flag, and checks every result in order.
// Depends on rhc_pkg and the rgb_to_hsi_convert RTL.
`timescale 1ns / 100ps

class hsi_scoreboard;
  typedef struct {
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] inten;
    logic        gray;
  } hsi_t;

  hsi_t pending[$];
  int   errors;

  // Floor shift of a signed value
  static function longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  // Angle of (x, y), y >= 0, 2^32 per turn
  static function logic [31:0] vector_angle(longint x, longint y);
    logic [31:0] ang;
    longint t, dx, dy;
    ang = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      ang = rhc_pkg::QUARTER_TURN;
    end
    for (int i = 0; i < rhc_pkg::FRAC_BITS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        ang += rhc_pkg::atan_turn(i[4:0]);
      end else if (y < 0) begin
        x -= dx;
        y += dy;
        ang -= rhc_pkg::atan_turn(i[4:0]);
      end else begin
        break;
      end
    end
    return ang;
  endfunction

  // Predict the result of one pixel and queue it
  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsi_t e;
    int unsigned sum, mn, dgb;
    longint x;
    longint unsigned yp;
    logic [31:0] ang;
    logic [32:0] rnd;
    sum = r + g + b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    e.gray = (r == g) && (g == b);
    e.inten = 16'((sum * 257) / 3);
    e.sat = (sum == 0) ? 16'd0 : 16'(65535 - (3 * mn * 65535) / sum);
    if (e.gray) begin
      e.hue = rhc_pkg::GRAY_HUE;
    end else begin
      x = longint'(2 * int'(r) - int'(g) - int'(b)) <<< rhc_pkg::FRAC_BITS;
      dgb = (g >= b) ? g - b : b - g;
      yp = (longint'(dgb) * 64'd1859775393 + (64'd1 << (29 - rhc_pkg::FRAC_BITS)))
           >> (30 - rhc_pkg::FRAC_BITS);
      ang = vector_angle(x, longint'(yp));
      if (b > g) ang = 32'd0 - ang;
      rnd = {1'b0, ang} + 33'h8000;
      e.hue = rnd[31:16];
    end
    pending = {pending, e};
  endfunction

  // Compare one accepted result with the oldest prediction
  function void check_result(logic [15:0] h, logic [15:0] s, logic [15:0] i, logic a);
    hsi_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected result hue=%0d sat=%0d int=%0d", h, s, i);
      return;
    end
    e = pending.pop_front();
    if (h !== e.hue || s !== e.sat || i !== e.inten || a !== e.gray) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: exp h=%0d s=%0d i=%0d a=%0d got h=%0d s=%0d i=%0d a=%0d",
                 e.hue, e.sat, e.inten, e.gray, h, s, i, a);
    end
  endfunction
endclass

module tb;
  localparam int WATCHDOG = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] red = '0, green = '0, blue = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [15:0] hue, saturation, intensity;
  logic achromatic;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;
  hsi_scoreboard pixel_check = new();

  rgb_to_hsi_convert u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .red(red), .green(green), .blue(blue), .out_valid(out_valid),
    .out_stall(out_stall), .hue(hue), .saturation(saturation),
    .intensity(intensity), .achromatic(achromatic)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Drive stall for the output side and check accepted items
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      pixel_check.check_result(hue, saturation, intensity, achromatic);
    if (rst) out_stall <= 1'b1;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Count cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one pixel and wait until it is accepted
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    pixel_check.note_pixel(r, g, b);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(int n);
    logic [7:0] r, g, b;
    for (int k = 0; k < n; k++) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(7))
        0: g = r;
        1: b = g;
        2: begin g = r; b = r; end
        3: begin
          r = 8'($urandom_range(3));
          g = 8'($urandom_range(3));
          b = 8'($urandom_range(3));
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: black, white, grays, primaries, hue wrap around
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd1);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd85);
    send_pixel(8'd0, 8'd128, 8'd127);

    // Random phases: none, sender idle, receiver stall, both
    send_random(270);
    send_idle_pct = 56;
    send_random(270);
    send_idle_pct = 0;
    recv_stall_pct = 56;
    send_random(270);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    send_random(150);

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (80) @(posedge clk);
        hold_off <= 1'b0;
      end
      send_random(120);
    join
    in_valid <= 1'b0;

    while (pixel_check.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pixel_check.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
